/* src/qwd_pkg.sv */
package qwd_pkg;

	localparam int DEPTH   = 16;
	localparam int TOKEN_W = 32;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_ENQ = 2'd0,
		REQ_DEQ = 2'd1,
		REQ_DEL = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DQ_WAIT,
		ST_SEARCH,
		ST_SHIFT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic               status;
		logic [TOKEN_W-1:0] token;
		logic [CNT_W-1:0]   count;
	} rsp_t;

	// Both operands are below DEPTH, so one conditional subtract wraps the sum.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W + 1)'(DEPTH)) begin
			s = s - (PTR_W + 1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

/* src/fifo_queue_with_delete.sv */
// From input acceptance, every request passes the dispatch state: enqueue and rejected
// requests go on to the response state, dequeue first waits for the memory read, and delete
// scans and then shifts the memory one entry per cycle through its single ports.
// A new item is accepted in the cycle after the previous result leaves the controller.
// Reset clears the count and head pointer; entry contents stay undefined until written.
module fifo_queue_with_delete (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] item_token,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [31:0] token_out,
	output logic [4:0]  entry_count
);
	import qwd_pkg::*;

	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	rsp_t out_q;
	logic out_valid_q;

	qwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.tok_in    (TOKEN_W'(item_token)),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign token_out   = 32'(out_q.token);
	assign entry_count = 5'(out_q.count);

endmodule

/* src/qwd_ram.sv */
module qwd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/qwd_ctrl.sv */
module qwd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [qwd_pkg::TOKEN_W-1:0] tok_in,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output qwd_pkg::rsp_t               rsp
);
	import qwd_pkg::*;

	state_t state_q, state_d;

	logic [1:0]         req_q;
	logic [TOKEN_W-1:0] tok_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   idx_q;
	rsp_t               res_q;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [TOKEN_W-1:0] ram_wdata;
	logic [PTR_W-1:0]   ram_raddr;
	logic [TOKEN_W-1:0] ram_rdata;

	logic [PTR_W-1:0] idx_p1;
	logic [PTR_W-1:0] idx_p2;
	logic             idx_last;
	logic             next_last;
	logic             hit;
	logic             enq_ok;

	qwd_ram #(.DEPTH(DEPTH), .WIDTH(TOKEN_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign idx_p1    = idx_q + PTR_W'(1);
	assign idx_p2    = idx_q + PTR_W'(2);
	assign idx_last  = ({1'b0, CNT_W'(idx_q)} + (CNT_W + 1)'(1)) == {1'b0, count_q};
	assign next_last = ({1'b0, CNT_W'(idx_q)} + (CNT_W + 1)'(2)) == {1'b0, count_q};
	assign hit       = ram_rdata == tok_q;
	assign enq_ok    = (tok_q != '0) && (count_q < CNT_W'(DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (req_q)
					REQ_DEQ: state_d = (count_q != '0) ? ST_DQ_WAIT : ST_RESP;
					REQ_DEL: state_d = (count_q != '0) ? ST_SEARCH : ST_RESP;
					default: state_d = ST_RESP;
				endcase
			end
			ST_DQ_WAIT: state_d = ST_RESP;
			ST_SEARCH: begin
				if (hit && !idx_last) begin
					state_d = ST_SHIFT;
				end else if (idx_last) begin
					state_d = ST_RESP;
				end
			end
			ST_SHIFT: begin
				if (next_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rsp_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wrap_add(head_q, idx_q);
		ram_wdata = tok_q;
		ram_raddr = head_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DISPATCH: begin
				if (req_q == REQ_ENQ && enq_ok) begin
					ram_we    = 1'b1;
					ram_waddr = wrap_add(head_q, PTR_W'(count_q));
				end
			end
			ST_SEARCH: ram_raddr = wrap_add(head_q, idx_p1);
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_raddr = wrap_add(head_q, idx_p2);
			end
			ST_RESP: rsp_valid = 1'b1;
			default: ;
		endcase
	end

	assign rsp = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DISPATCH: begin
					if (req_q == REQ_ENQ && enq_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_DQ_WAIT: begin
					head_q  <= wrap_add(head_q, PTR_W'(1));
					count_q <= count_q - CNT_W'(1);
				end
				ST_SEARCH: begin
					if (hit && idx_last) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (next_last) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req_type;
				tok_q <= tok_in;
			end
			ST_DISPATCH: begin
				idx_q        <= '0;
				res_q.token  <= '0;
				res_q.status <= !(req_q == REQ_ENQ && enq_ok);
				res_q.count  <= (req_q == REQ_ENQ && enq_ok) ? count_q + CNT_W'(1)
					: count_q;
			end
			ST_DQ_WAIT: begin
				res_q.status <= 1'b0;
				res_q.token  <= ram_rdata;
				res_q.count  <= count_q - CNT_W'(1);
			end
			ST_SEARCH: begin
				if (hit) begin
					res_q.status <= 1'b0;
					res_q.count  <= count_q - CNT_W'(1);
				end else begin
					idx_q <= idx_p1;
				end
			end
			ST_SHIFT: idx_q <= idx_p1;
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Entry count exceeds the queue depth.");

	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH || state_q == ST_SHIFT || state_q == ST_DQ_WAIT)
		|-> count_q != '0)
		else $error("Memory is read while the queue is empty.");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && !next_last) |-> ram_waddr != ram_raddr)
		else $error("Shift writes the entry it reads in the same cycle.");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_DISPATCH || state_q == ST_SHIFT))
		else $error("Memory written outside enqueue or shift.");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_DISPATCH)
		else $error("Accepted item did not start dispatch.");

endmodule
